@@ hdl/u8u16_pkg.sv @@
// shared types and constants for the utf-8 to utf-16 transcoder
package u8u16_pkg;

    // default depth of the internal queues
    localparam int QUEUE_DEPTH_DEF = 2;

    // code point and code unit widths
    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;

    // lead byte classes, given as sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // surrogate constants
    localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] HIGH_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_BASE  = 16'hDC00;

    // one input transaction
    typedef struct packed {
        logic [7:0] byte_value;
        logic       string_end;
    } byte_in_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        text_last;
    } unit_out_t;

    // decoded code point handed from front to back
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            text_end;
    } cp_entry_t;

endpackage

@@ hdl/u8u16_fifo.sv @@
// small register queue used between the stages and at the output
module u8u16_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/u8u16_front.sv @@
// byte classifier and code point accumulator
module u8u16_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  u8u16_pkg::byte_in_t   item,
    output logic                  cp_valid,
    output u8u16_pkg::cp_entry_t  cp_entry
);
    import u8u16_pkg::*;

    logic [2:0]      seq_len_reg, seq_len_next;
    logic [2:0]      taken_reg, taken_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [2:0]      len;
    logic [2:0]      taken;
    logic [2:0]      remain;
    logic [4:0]      shift;
    logic [CP_W-1:0] cp_acc;
    logic [7:0]      b;
    logic            done;

    assign b = item.byte_value;

    // classify a lead or merge a continuation byte
    always_comb
    begin
        len    = seq_len_reg;
        taken  = taken_reg;
        remain = '0;
        shift  = '0;
        cp_acc = cp_reg;
        if (seq_len_reg == LEN_NONE)
        begin
            taken = 3'd1;
            if (!b[7])
            begin
                len    = LEN_ONE;
                cp_acc = {13'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                len    = LEN_TWO;
                cp_acc = {10'd0, b[4:0], 6'd0};
            end
            else if (b[7:4] == 4'b1110)
            begin
                len    = LEN_THREE;
                cp_acc = {5'd0, b[3:0], 12'd0};
            end
            else
            begin
                len    = LEN_FOUR;
                cp_acc = {b[2:0], 18'd0};
            end
            done = (len == LEN_ONE) || item.string_end;
        end
        else
        begin
            taken  = taken_reg + 3'd1;
            remain = (taken <= len) ? (len - taken) : 3'd0;
            case (remain)
                3'd1:    shift = 5'd6;
                3'd2:    shift = 5'd12;
                3'd3:    shift = 5'd18;
                default: shift = 5'd0;
            endcase
            cp_acc = cp_reg | (CP_W'({15'd0, b[5:0]}) << shift);
            done   = (taken >= len) || item.string_end;
        end
    end

    // state update on each accepted byte
    always_comb
    begin
        seq_len_next = seq_len_reg;
        taken_next   = taken_reg;
        cp_next      = cp_reg;
        if (accept)
        begin
            if (done)
            begin
                seq_len_next = LEN_NONE;
                taken_next   = '0;
                cp_next      = '0;
            end
            else
            begin
                seq_len_next = len;
                taken_next   = taken;
                cp_next      = cp_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= LEN_NONE;
            taken_reg   <= '0;
            cp_reg      <= '0;
        end
        else
        begin
            seq_len_reg <= seq_len_next;
            taken_reg   <= taken_next;
            cp_reg      <= cp_next;
        end
    end

    // finished code point goes to the queue
    assign cp_valid            = accept && done;
    assign cp_entry.code_point = cp_acc;
    assign cp_entry.text_end   = item.string_end;

endmodule

@@ hdl/u8u16_back.sv @@
// code point to utf-16 unit generator, one unit per cycle unless the result queue is full or no code point waits
module u8u16_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cp_empty,
    input  u8u16_pkg::cp_entry_t  cp_entry,
    output logic                  cp_pop,
    input  logic                  unit_full,
    output logic                  unit_push,
    output u8u16_pkg::unit_out_t  unit
);
    import u8u16_pkg::*;

    logic            phase_reg, phase_next;
    logic            is_pair;
    logic [CP_W-1:0] offset;
    logic [UNIT_W-1:0] high_half;
    logic [UNIT_W-1:0] low_half;

    // surrogate halves
    assign is_pair   = |cp_entry.code_point[CP_W-1:16];
    assign offset    = cp_entry.code_point - SUPP_BASE;
    assign high_half = HIGH_BASE + {5'd0, offset[CP_W-1:10]};
    assign low_half  = LOW_BASE | {6'd0, offset[9:0]};

    // select the unit for this cycle
    always_comb
    begin
        if (phase_reg)
        begin
            unit.code_unit = low_half;
        end
        else if (is_pair)
        begin
            unit.code_unit = high_half;
        end
        else
        begin
            unit.code_unit = cp_entry.code_point[UNIT_W-1:0];
        end
        unit.run_last  = !is_pair || phase_reg;
        unit.text_last = unit.run_last && cp_entry.text_end;
    end

    assign unit_push = !cp_empty && !unit_full;
    assign cp_pop    = unit_push && unit.run_last;

    // second half pending after a high surrogate
    always_comb
    begin
        phase_next = phase_reg;
        if (unit_push)
        begin
            phase_next = is_pair && !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

@@ hdl/utf8_to_utf16_transcoder.sv @@
// top level of the utf-8 to utf-16 transcoder
//
// Bytes enter through a queue-style port (push/full) at up to one per cycle,
// and utf-16 units leave through a second queue (empty/pop) at up to one per cycle.
// The front stage classifies each byte and builds the code point in the same
// cycle it is taken; a finished code point goes into a small queue, and the
// back stage turns it into one unit, or into a high and a low surrogate unit.
// A byte that completes a sequence writes its code point into the code point
// queue; the back stage then writes its first unit into the result queue, from
// which it can be popped. Sustained input rate is one byte per cycle, limited
// only by the one-unit-per-cycle output port when surrogate pairs arrive
// densely, and by pop stalls once both queues fill. Decoding is lenient:
// continuation bytes are not checked, odd leads act as four-byte leads, and a
// string that ends mid-sequence fills the missing bits with zero.
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  u8u16_pkg::byte_in_t  item,
    output logic                 empty,
    input  logic                 pop,
    output u8u16_pkg::unit_out_t result
);
    import u8u16_pkg::*;

    logic      accept;
    logic      cp_valid;
    cp_entry_t cp_wr;
    cp_entry_t cp_rd;
    logic      cp_empty;
    logic      cp_pop;
    logic      unit_full;
    logic      unit_push;
    unit_out_t unit_wr;

    assign accept = push && !full;

    // byte decode
    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cp_valid (cp_valid),
        .cp_entry (cp_wr)
    );

    // code point queue
    u8u16_fifo #(
        .WIDTH ($bits(cp_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cp_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cp_valid),
        .wr_data (cp_wr),
        .full    (full),
        .rd_en   (cp_pop),
        .rd_data (cp_rd),
        .empty   (cp_empty)
    );

    // unit generation
    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cp_empty  (cp_empty),
        .cp_entry  (cp_rd),
        .cp_pop    (cp_pop),
        .unit_full (unit_full),
        .unit_push (unit_push),
        .unit      (unit_wr)
    );

    // result queue
    u8u16_fifo #(
        .WIDTH ($bits(unit_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_unit_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (unit_push),
        .wr_data (unit_wr),
        .full    (unit_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
